>>> rtl/spc_pkg.sv
// Shared widths, codes and types of the sprite pixel collision block.
// Used by the item channel interface, the top level and the bench; depends on nothing.
package spc_pkg;

    localparam int MAX_PIXELS_DEF = 4096;
    localparam int MAX_SIDE_DEF   = 64;

    localparam int SIDE_W   = 7;
    localparam int KEY_W    = 24;
    localparam int PIXEL_W  = 32;
    localparam int INDEX_W  = 12;
    localparam int POS_W    = 16;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_WRITE_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A_ALPHA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ALPHA  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_A_KEY    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_B_KEY    = 3'd7;

    // Overlap of one axis: both boxes touch, offsets into A and B, span length
    typedef struct packed {
        logic              ok;
        logic [SIDE_W-1:0] oa;
        logic [SIDE_W-1:0] ob;
        logic [SIDE_W-1:0] len;
    } t_axis;

endpackage

>>> rtl/spc_item_if.sv
// Input channel of the sprite pixel collision block: valid/ready plus one item.
// Depends on spc_pkg.
interface spc_item_if
    import spc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [INDEX_W-1:0]       pixel_index;
    logic [PIXEL_W-1:0]       pixel_value;
    logic signed [POS_W-1:0]  a_pos_x;
    logic signed [POS_W-1:0]  a_pos_y;
    logic signed [POS_W-1:0]  b_pos_x;
    logic signed [POS_W-1:0]  b_pos_y;

    modport source (
        output valid, kind, pixel_index, pixel_value, a_pos_x, a_pos_y, b_pos_x, b_pos_y,
        input  ready
    );
    modport sink (
        input  valid, kind, pixel_index, pixel_value, a_pos_x, a_pos_y, b_pos_x, b_pos_y,
        output ready
    );
endinterface

>>> rtl/spc_result_if.sv
// Result channel of the sprite pixel collision block: valid/ready plus one result.
// Depends on nothing beyond the language.
interface spc_result_if;
    logic valid;
    logic ready;
    logic hit;
    logic boxes_overlap;

    modport source (output valid, hit, boxes_overlap, input ready);
    modport sink   (input valid, hit, boxes_overlap, output ready);
endinterface

>>> rtl/sprite_pixel_collision_top.sv
// Sprite pixel collision top level: two pixel stores, box test and overlap walk.
// Depends on spc_pkg, spc_item_if and spc_result_if.
//
// Pixel writes (kind A or B) are taken while idle and give no result; an
// unknown kind is taken and dropped. A query is taken while idle and runs the
// box test (one shared axis unit, x then y). When the boxes overlap, both
// sprites use the same mode and both spans are non-empty, it forms the row-major
// start addresses (one shared 7x7 multiplier), then walks the overlap row by
// row: each row wraps the start addresses, taking MAX_PIXELS off each one that
// is not below MAX_PIXELS until both are, and loads the pointers, and each pixel
// is a registered store read, then the solid test. The walk stops at the first
// solid pair, and the result then moves to the output register.
// The result sits in that register, so the next item is taken while it waits; a
// query that finishes while that register is still full holds until it drains.
// The stores have no reset and need no clearing.
module sprite_pixel_collision_top
    import spc_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF,
    parameter int MAX_SIDE   = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    spc_item_if.sink              i_item,
    spc_result_if.source          o_result
);

    localparam int AW     = $clog2(MAX_PIXELS);
    localparam int BASE_W = (AW + 1 > 2 * SIDE_W) ? AW + 1 : 2 * SIDE_W;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_AXIS_X = 10'b00_0000_0010,
        S_AXIS_Y = 10'b00_0000_0100,
        S_BASE_A = 10'b00_0000_1000,
        S_BASE_B = 10'b00_0001_0000,
        S_WRAP   = 10'b00_0010_0000,
        S_ROW    = 10'b00_0100_0000,
        S_READ   = 10'b00_1000_0000,
        S_CHECK  = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    // Configuration
    logic [SIDE_W-1:0] r_a_width, r_a_height, r_b_width, r_b_height;
    logic              r_a_alpha, r_b_alpha;
    logic [KEY_W-1:0]  r_a_key, r_b_key;
    logic [SIDE_W-1:0] w_side;

    // Sequencer and walk state
    t_state                  r_state, n_state;
    logic signed [POS_W-1:0] r_ax, r_ay, r_bx, r_by;
    logic                    r_okx, n_okx;
    logic [SIDE_W-1:0]       r_oax, n_oax, r_obx, n_obx, r_cw, n_cw;
    logic [SIDE_W-1:0]       r_oay, n_oay, r_oby, n_oby, r_ch, n_ch;
    logic                    r_box, n_box;
    logic                    r_hit, n_hit;
    logic [BASE_W-1:0]       r_base_a, n_base_a, r_base_b, n_base_b;
    logic [AW-1:0]           r_ptr_a, n_ptr_a, r_ptr_b, n_ptr_b;
    logic [SIDE_W-1:0]       r_col, n_col, r_row, n_row;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_hit, n_out_hit, r_out_box, n_out_box;

    // Stores
    logic [PIXEL_W-1:0] r_mem_a [MAX_PIXELS];
    logic [PIXEL_W-1:0] r_mem_b [MAX_PIXELS];
    logic [PIXEL_W-1:0] r_rd_a, r_rd_b;

    logic              w_accept;
    logic              w_we_a, w_we_b;
    logic [AW-1:0]     w_waddr;
    t_axis             w_axis;
    logic [SIDE_W-1:0] w_mul_x, w_mul_w;
    logic [2*SIDE_W-1:0] w_prod;
    logic              w_solid_a, w_solid_b;

    function automatic t_axis axis_span(
        input logic signed [POS_W-1:0] pa,
        input logic signed [POS_W-1:0] pb,
        input logic [SIDE_W-1:0]       sa,
        input logic [SIDE_W-1:0]       sb
    );
        logic signed [POS_W+1:0] d;
        logic signed [POS_W+1:0] sa_s;
        logic signed [POS_W+1:0] sb_s;
        logic signed [POS_W+1:0] l1;
        t_axis r;
        d    = {{2{pa[POS_W-1]}}, pa} - {{2{pb[POS_W-1]}}, pb};
        sa_s = (POS_W+2)'(sa);
        sb_s = (POS_W+2)'(sb);
        r.ok = (d <= sb_s) && (d >= -sa_s);
        if (d > 0) begin
            r.oa  = '0;
            r.ob  = SIDE_W'(d);
            l1    = sb_s - d;
            r.len = (l1 < sa_s) ? SIDE_W'(l1) : sa;
        end else begin
            r.oa  = SIDE_W'(-d);
            r.ob  = '0;
            l1    = sa_s + d;
            r.len = (l1 < sb_s) ? SIDE_W'(l1) : sb;
        end
        return r;
    endfunction

    assign i_item.ready          = (r_state == S_IDLE);
    assign w_accept              = i_item.valid && i_item.ready;
    assign o_result.valid        = r_out_valid;
    assign o_result.hit          = r_out_hit;
    assign o_result.boxes_overlap = r_out_box;

    // Sizes saturate on write
    assign w_side = (32'(i_cfg_data[SIDE_W-1:0]) > MAX_SIDE) ? SIDE_W'(MAX_SIDE)
                                                             : i_cfg_data[SIDE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_width  <= '0;
            r_a_height <= '0;
            r_b_width  <= '0;
            r_b_height <= '0;
            r_a_alpha  <= 1'b1;
            r_b_alpha  <= 1'b1;
            r_a_key    <= '0;
            r_b_key    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_A_WIDTH:  r_a_width  <= w_side;
                CFG_A_HEIGHT: r_a_height <= w_side;
                CFG_B_WIDTH:  r_b_width  <= w_side;
                CFG_B_HEIGHT: r_b_height <= w_side;
                CFG_A_ALPHA:  r_a_alpha  <= i_cfg_data[0];
                CFG_B_ALPHA:  r_b_alpha  <= i_cfg_data[0];
                CFG_A_KEY:    r_a_key    <= i_cfg_data[KEY_W-1:0];
                CFG_B_KEY:    r_b_key    <= i_cfg_data[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    // Drop writes beyond the store
    assign w_waddr = AW'(i_item.pixel_index);
    assign w_we_a  = w_accept && (i_item.kind == KIND_WRITE_A)
                     && (32'(i_item.pixel_index) < MAX_PIXELS);
    assign w_we_b  = w_accept && (i_item.kind == KIND_WRITE_B)
                     && (32'(i_item.pixel_index) < MAX_PIXELS);

    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            r_mem_a[w_waddr] <= i_item.pixel_value;
        end
        r_rd_a <= r_mem_a[r_ptr_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            r_mem_b[w_waddr] <= i_item.pixel_value;
        end
        r_rd_b <= r_mem_b[r_ptr_b];
    end

    // One axis unit serves x then y
    always_comb begin
        if (r_state == S_AXIS_X) begin
            w_axis = axis_span(r_ax, r_bx, r_a_width, r_b_width);
        end else begin
            w_axis = axis_span(r_ay, r_by, r_a_height, r_b_height);
        end
    end

    // One multiplier serves both start addresses
    assign w_mul_x = (r_state == S_BASE_A) ? r_oay : r_oby;
    assign w_mul_w = (r_state == S_BASE_A) ? r_a_width : r_b_width;
    assign w_prod  = (2*SIDE_W)'(w_mul_x) * (2*SIDE_W)'(w_mul_w);

    assign w_solid_a = r_a_alpha ? (r_rd_a[PIXEL_W-1:KEY_W] != '0)
                                 : (r_rd_a[KEY_W-1:0] != r_a_key);
    assign w_solid_b = r_b_alpha ? (r_rd_b[PIXEL_W-1:KEY_W] != '0)
                                 : (r_rd_b[KEY_W-1:0] != r_b_key);

    always_comb begin
        n_state     = r_state;
        n_okx       = r_okx;
        n_oax       = r_oax;
        n_obx       = r_obx;
        n_cw        = r_cw;
        n_oay       = r_oay;
        n_oby       = r_oby;
        n_ch        = r_ch;
        n_box       = r_box;
        n_hit       = r_hit;
        n_base_a    = r_base_a;
        n_base_b    = r_base_b;
        n_ptr_a     = r_ptr_a;
        n_ptr_b     = r_ptr_b;
        n_col       = r_col;
        n_row       = r_row;
        n_out_hit   = r_out_hit;
        n_out_box   = r_out_box;
        n_out_valid = r_out_valid && !o_result.ready;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_item.kind == KIND_QUERY)) begin
                    n_state = S_AXIS_X;
                end
            end
            S_AXIS_X: begin
                n_okx   = w_axis.ok;
                n_oax   = w_axis.oa;
                n_obx   = w_axis.ob;
                n_cw    = w_axis.len;
                n_state = S_AXIS_Y;
            end
            S_AXIS_Y: begin
                n_oay = w_axis.oa;
                n_oby = w_axis.ob;
                n_ch  = w_axis.len;
                n_box = r_okx && w_axis.ok;
                n_hit = 1'b0;
                // Mixed modes and empty spans never hit
                if (r_okx && w_axis.ok && (r_a_alpha == r_b_alpha)
                        && (r_cw != '0) && (w_axis.len != '0)) begin
                    n_state = S_BASE_A;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BASE_A: begin
                n_base_a = BASE_W'(w_prod) + BASE_W'(r_oax);
                n_row    = '0;
                n_state  = S_BASE_B;
            end
            S_BASE_B: begin
                n_base_b = BASE_W'(w_prod) + BASE_W'(r_obx);
                n_state  = S_WRAP;
            end
            S_WRAP: begin
                if (r_base_a >= BASE_W'(MAX_PIXELS)) begin
                    n_base_a = r_base_a - BASE_W'(MAX_PIXELS);
                end
                if (r_base_b >= BASE_W'(MAX_PIXELS)) begin
                    n_base_b = r_base_b - BASE_W'(MAX_PIXELS);
                end
                if ((r_base_a < BASE_W'(MAX_PIXELS)) && (r_base_b < BASE_W'(MAX_PIXELS))) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_ptr_a = AW'(r_base_a);
                n_ptr_b = AW'(r_base_b);
                n_col   = '0;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_solid_a && w_solid_b) begin
                    n_hit   = 1'b1;
                    n_state = S_DONE;
                end else if (r_col != r_cw - 1'b1) begin
                    n_col   = r_col + 1'b1;
                    n_ptr_a = (r_ptr_a == AW'(MAX_PIXELS - 1)) ? '0 : r_ptr_a + 1'b1;
                    n_ptr_b = (r_ptr_b == AW'(MAX_PIXELS - 1)) ? '0 : r_ptr_b + 1'b1;
                    n_state = S_READ;
                end else if (r_row != r_ch - 1'b1) begin
                    n_row    = r_row + 1'b1;
                    n_base_a = r_base_a + BASE_W'(r_a_width);
                    n_base_b = r_base_b + BASE_W'(r_b_width);
                    n_state  = S_WRAP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_out_box   = r_box;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ax <= i_item.a_pos_x;
            r_ay <= i_item.a_pos_y;
            r_bx <= i_item.b_pos_x;
            r_by <= i_item.b_pos_y;
        end
        r_okx     <= n_okx;
        r_oax     <= n_oax;
        r_obx     <= n_obx;
        r_cw      <= n_cw;
        r_oay     <= n_oay;
        r_oby     <= n_oby;
        r_ch      <= n_ch;
        r_box     <= n_box;
        r_hit     <= n_hit;
        r_base_a  <= n_base_a;
        r_base_b  <= n_base_b;
        r_ptr_a   <= n_ptr_a;
        r_ptr_b   <= n_ptr_b;
        r_col     <= n_col;
        r_row     <= n_row;
        r_out_hit <= n_out_hit;
        r_out_box <= n_out_box;
    end

endmodule

>>> bench/tb_sprite_pixel_collision_top.sv
`timescale 1ns / 100ps
// Self-checking bench for sprite_pixel_collision_top: loads both sprite stores, sends
// collision queries and checks each result against a predictor kept in the bench.
// Depends on spc_pkg, spc_item_if, spc_result_if and the top level.
module tb_sprite_pixel_collision_top;
    import spc_pkg::*;

    localparam int STORE_DEPTH   = MAX_PIXELS_DEF;
    localparam int SIDE_LIMIT    = MAX_SIDE_DEF;
    localparam int QUIET_LIMIT   = 20000;
    localparam int CHOKE_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef enum int {PACE_FULL, PACE_RANDOM, PACE_BURSTY} t_pace;

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic [INDEX_W-1:0]      index;
        logic [PIXEL_W-1:0]      value;
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
        logic signed [POS_W-1:0] bx;
        logic signed [POS_W-1:0] by;
    } t_sprite_op;

    typedef struct {
        logic hit;
        logic boxes_overlap;
    } t_collision;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    spc_item_if   item_ch ();
    spc_result_if result_ch ();

    sprite_pixel_collision_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    // Shadow of the block: stores and registers
    logic [PIXEL_W-1:0] pic_a [STORE_DEPTH];
    logic [PIXEL_W-1:0] pic_b [STORE_DEPTH];
    int                 a_w, a_h, b_w, b_h;
    bit                 a_alpha, b_alpha;
    logic [KEY_W-1:0]   a_key, b_key;

    t_sprite_op pending_ops [$];
    t_collision awaited_results [$];
    t_sprite_op cur_op;
    t_collision want;
    t_pace      send_pace = PACE_FULL;
    t_pace      recv_pace = PACE_FULL;
    int         send_gap, recv_stall;
    int         choke_asked = 0;
    int         choke_done = 0;
    int         err_count = 0;
    int         results_seen = 0;
    int         quiet_cycles = 0;
    logic       offer_next;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_gap(t_pace pace);
        case (pace)
            PACE_FULL:   return 0;
            PACE_RANDOM: return $urandom_range(0, 15);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
        endcase
    endfunction

    function automatic bit is_solid(logic [PIXEL_W-1:0] px, bit alpha_mode,
                                    logic [KEY_W-1:0] key);
        if (alpha_mode)
            return px[31:24] != 8'h00;
        return px[23:0] != key;
    endfunction

    // One axis of the overlap: offsets into each sprite and the span length
    function automatic void axis_span(input int pa, input int sa, input int pb, input int sb,
                                      output int oa, output int ob, output int len);
        int d;
        d   = (pa > pb) ? pa - pb : pb - pa;
        oa  = (pa > pb) ? 0 : d;
        ob  = (pa > pb) ? d : 0;
        len = (pa > pb) ? sb - d : sa - d;
        if (sa < len) len = sa;
        if (sb < len) len = sb;
    endfunction

    function automatic t_collision predict_collision(t_sprite_op op);
        t_collision r;
        int ax, ay, bx, by;
        int oax, obx, cw, oay, oby, ch, ia, ib;
        ax = op.ax;
        ay = op.ay;
        bx = op.bx;
        by = op.by;
        r.hit = 1'b0;
        r.boxes_overlap = (ax <= bx + b_w) && (bx <= ax + a_w) &&
                          (ay <= by + b_h) && (by <= ay + a_h);
        if (r.boxes_overlap && a_alpha == b_alpha) begin
            axis_span(ax, a_w, bx, b_w, oax, obx, cw);
            axis_span(ay, a_h, by, b_h, oay, oby, ch);
            for (int x = 0; x < cw && !r.hit; x++) begin
                for (int y = 0; y < ch && !r.hit; y++) begin
                    ia = ((y + oay) * a_w + x + oax) % STORE_DEPTH;
                    ib = ((y + oby) * b_w + x + obx) % STORE_DEPTH;
                    if (is_solid(pic_a[ia], a_alpha, a_key) &&
                        is_solid(pic_b[ib], b_alpha, b_key))
                        r.hit = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // Sender: present queued items, apply each transfer to the shadow
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            offer_next = item_ch.valid;
            if (item_ch.valid && item_ch.ready) begin
                case (cur_op.kind)
                    KIND_WRITE_A: pic_a[cur_op.index] = cur_op.value;
                    KIND_WRITE_B: pic_b[cur_op.index] = cur_op.value;
                    KIND_QUERY:   awaited_results.push_back(predict_collision(cur_op));
                    default: ;
                endcase
                offer_next = 1'b0;
                send_gap = draw_gap(send_pace);
            end
            if (!offer_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() != 0) begin
                    cur_op = pending_ops.pop_front();
                    item_ch.kind        <= cur_op.kind;
                    item_ch.pixel_index <= cur_op.index;
                    item_ch.pixel_value <= cur_op.value;
                    item_ch.a_pos_x     <= cur_op.ax;
                    item_ch.a_pos_y     <= cur_op.ay;
                    item_ch.b_pos_x     <= cur_op.bx;
                    item_ch.b_pos_y     <= cur_op.by;
                    offer_next = 1'b1;
                end
            end
            item_ch.valid <= offer_next;
        end
    end

    // Receiver: check each transfer, then stall as the pace says
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no query waiting", results_seen));
                end else begin
                    want = awaited_results.pop_front();
                    if (result_ch.hit !== want.hit)
                        report_mismatch($sformatf("result %0d hit %b, want %b",
                                                  results_seen, result_ch.hit, want.hit));
                    if (result_ch.boxes_overlap !== want.boxes_overlap)
                        report_mismatch($sformatf("result %0d boxes_overlap %b, want %b",
                                                  results_seen, result_ch.boxes_overlap,
                                                  want.boxes_overlap));
                end
                recv_stall = draw_gap(recv_pace);
            end
            if (choke_done != choke_asked) begin
                choke_done = choke_asked;
                recv_stall = CHOKE_CYCLES;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || item_ch.valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        int side;
        side = value & 32'h7F;
        if (side > SIDE_LIMIT) side = SIDE_LIMIT;
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_A_WIDTH:  a_w = side;
            CFG_A_HEIGHT: a_h = side;
            CFG_B_WIDTH:  b_w = side;
            CFG_B_HEIGHT: b_h = side;
            CFG_A_ALPHA:  a_alpha = value[0];
            CFG_B_ALPHA:  b_alpha = value[0];
            CFG_A_KEY:    a_key = value[KEY_W-1:0];
            default:      b_key = value[KEY_W-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_op(input logic [KIND_W-1:0] kind, input int idx, input int val,
                           input int ax, input int ay, input int bx, input int by);
        t_sprite_op op;
        op.kind  = kind;
        op.index = INDEX_W'(idx);
        op.value = PIXEL_W'(val);
        op.ax    = POS_W'(ax);
        op.ay    = POS_W'(ay);
        op.bx    = POS_W'(bx);
        op.by    = POS_W'(by);
        pending_ops.push_back(op);
    endtask

    task automatic push_write(input logic [KIND_W-1:0] kind, input int idx, input int val);
        push_op(kind, idx, val, $urandom, $urandom, $urandom, $urandom);
    endtask

    // density: percent chance that a pixel is solid in each mode
    function automatic logic [PIXEL_W-1:0] paint(int density, logic [KEY_W-1:0] key);
        logic [7:0]       alpha;
        logic [KEY_W-1:0] rgb;
        alpha = ($urandom_range(0, 99) < density) ? 8'($urandom_range(1, 255)) : 8'h00;
        rgb   = ($urandom_range(0, 99) < density) ? KEY_W'($urandom) : key;
        return {alpha, rgb};
    endfunction

    task automatic push_query();
        int ax, ay, bx, by, pick;
        pick = $urandom_range(0, 19);
        ax = $urandom_range(0, 65535) - 32768;
        ay = $urandom_range(0, 65535) - 32768;
        bx = ax + $urandom_range(0, a_w + b_w + 2) - b_w - 1;
        by = ay + $urandom_range(0, a_h + b_h + 2) - b_h - 1;
        if (pick < 3) begin
            // edges meet exactly on one axis
            if (pick == 0) bx = ax + a_w;
            else if (pick == 1) bx = ax - b_w;
            else by = ($urandom_range(0, 1) == 0) ? ay + a_h : ay - b_h;
        end else if (pick < 6) begin
            bx = $urandom_range(0, 65535) - 32768;
            by = $urandom_range(0, 65535) - 32768;
        end
        push_op(KIND_QUERY, $urandom, $urandom, ax, ay, bx, by);
    endtask

    task automatic configure(input int aw, input int ah, input int bw, input int bh,
                             input bit aa, input bit ba, input int ak, input int bk);
        wait_idle();
        write_reg(CFG_A_WIDTH, aw);
        write_reg(CFG_A_HEIGHT, ah);
        write_reg(CFG_B_WIDTH, bw);
        write_reg(CFG_B_HEIGHT, bh);
        write_reg(CFG_A_ALPHA, aa);
        write_reg(CFG_B_ALPHA, ba);
        write_reg(CFG_A_KEY, ak);
        write_reg(CFG_B_KEY, bk);
        @(negedge i_clk);
    endtask

    // Load every pixel that a query can read, then mix queries with noise
    task automatic run_phase(input int aw, input int ah, input int bw, input int bh,
                             input bit aa, input bit ba, input int ak, input int bk,
                             input int density, input int n_ops, input bit choke);
        int left, chunk;
        configure(aw, ah, bw, bh, aa, ba, ak, bk);
        send_pace = t_pace'($urandom_range(0, 2));
        recv_pace = t_pace'($urandom_range(0, 2));
        for (int i = 0; i < a_w * a_h; i++)
            push_write(KIND_WRITE_A, i, paint(density, a_key));
        for (int i = 0; i < b_w * b_h; i++)
            push_write(KIND_WRITE_B, i, paint(density, b_key));
        while (pending_ops.size() != 0) @(negedge i_clk);
        if (choke) begin
            send_pace = PACE_FULL;
            choke_asked++;
        end
        left = n_ops;
        while (left > 0) begin
            chunk = choke ? left : $urandom_range(1, 12);
            if (chunk > left) chunk = left;
            if (!choke) begin
                send_pace = t_pace'($urandom_range(0, 2));
                recv_pace = t_pace'($urandom_range(0, 2));
            end
            repeat (chunk) begin
                case ($urandom_range(0, 9))
                    0: push_write(KIND_WRITE_A, $urandom_range(0, STORE_DEPTH - 1),
                                  paint(density, a_key));
                    1: push_write(KIND_WRITE_B, $urandom_range(0, STORE_DEPTH - 1),
                                  paint(density, b_key));
                    2: push_write(KIND_UNUSED, $urandom, $urandom);
                    default: push_query();
                endcase
            end
            left -= chunk;
            // now and then hold off until every answer is back
            if ($urandom_range(0, 2) == 0)
                wait_idle();
            else
                while (pending_ops.size() != 0) @(negedge i_clk);
        end
    endtask

    function automatic int pick_side();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return $urandom_range(SIDE_LIMIT, 127);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int pick_key();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 24'hFFFFFF;
            default: return $urandom_range(0, 24'hFFFFFF);
        endcase
    endfunction

    initial begin
        int aw, ah, bw, bh;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        item_ch.valid       = 1'b0;
        item_ch.kind        = '0;
        item_ch.pixel_index = '0;
        item_ch.pixel_value = '0;
        item_ch.a_pos_x     = '0;
        item_ch.a_pos_y     = '0;
        item_ch.b_pos_x     = '0;
        item_ch.b_pos_y     = '0;
        result_ch.ready     = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            pic_a[i] = '0;
            pic_b[i] = '0;
        end
        a_w = 0; a_h = 0; b_w = 0; b_h = 0;
        a_alpha = 1'b1; b_alpha = 1'b1;
        a_key = '0; b_key = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 2x2 sprites in alpha mode, field extremes and edge contact
        configure(2, 2, 2, 2, 1'b1, 1'b1, 0, 0);
        push_write(KIND_WRITE_A, 0, 32'hFFFFFFFF);
        push_write(KIND_WRITE_A, 1, 32'h00000000);
        push_write(KIND_WRITE_A, 2, 32'h00FFFFFF);
        push_write(KIND_WRITE_A, 3, 32'h01000000);
        push_write(KIND_WRITE_B, 0, 32'h00000000);
        push_write(KIND_WRITE_B, 1, 32'h80123456);
        push_write(KIND_WRITE_B, 2, 32'hFF000000);
        push_write(KIND_WRITE_B, 3, 32'h00000000);
        push_write(KIND_WRITE_A, STORE_DEPTH - 1, 32'h00000000);
        push_write(KIND_WRITE_B, STORE_DEPTH - 1, 32'hFFFFFFFF);
        push_op(KIND_QUERY, 0, 0, 0, 0, 0, 0);
        push_op(KIND_QUERY, 0, 0, 0, 0, 1, 1);
        push_op(KIND_QUERY, 0, 0, 0, 0, -1, -1);
        push_op(KIND_QUERY, 0, 0, 1, 0, 0, 1);
        push_op(KIND_QUERY, 0, 0, 0, 0, 2, 0);
        push_op(KIND_QUERY, 0, 0, 0, 0, 0, -2);
        push_op(KIND_QUERY, 0, 0, 0, 0, 3, 0);
        push_op(KIND_UNUSED, 32'hFFF, 32'hFFFFFFFF, -1, -1, -1, -1);
        push_op(KIND_QUERY, 32'hFFF, 32'hFFFFFFFF, -32768, -32768, 32767, 32767);
        push_op(KIND_QUERY, 0, 0, 32767, 32767, 32767, 32767);
        push_op(KIND_QUERY, 0, 0, -32768, -32768, -32768, -32767);
        push_op(KIND_QUERY, 0, 0, 32767, -32768, -32767, 32766);

        // Zero size, key mode, both mixed modes, saturated sides
        run_phase(0, 4, 3, 0, 1'b1, 1'b1, 0, 0, 50, 8, 1'b0);
        run_phase(4, 4, 5, 3, 1'b0, 1'b0, 24'hFFFFFF, 0, 30, 14, 1'b0);
        run_phase(4, 4, 4, 4, 1'b1, 1'b0, 0, 24'h123456, 60, 12, 1'b0);
        run_phase(3, 5, 4, 4, 1'b0, 1'b1, 24'hABCDEF, 0, 60, 12, 1'b0);
        run_phase(64, 1, 1, 90, 1'b0, 1'b0, 24'hFFFFFF, 0, 25, 24, 1'b0);
        run_phase(127, 2, 3, 3, 1'b1, 1'b1, 0, 0, 10, 20, 1'b0);
        // B over the far end of the full-width A reaches its last loaded pixel
        push_op(KIND_QUERY, 0, 0, 100, 200, 161, 199);
        wait_idle();

        // Long receiver stall while the sender keeps offering
        run_phase(6, 5, 4, 7, 1'b1, 1'b1, 0, 0, 8, 40, 1'b1);

        for (int p = 0; p < 2; p++) begin
            aw = pick_side();
            ah = pick_side();
            bw = pick_side();
            bh = pick_side();
            if (aw > 8 && ah > 8) ah = $urandom_range(0, 3);
            if (bw > 8 && bh > 8) bh = $urandom_range(0, 3);
            run_phase(aw, ah, bw, bh, $urandom_range(0, 1), $urandom_range(0, 1),
                      pick_key(), pick_key(), $urandom_range(2, 40), 50, 1'b0);
        end

        wait_idle();
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/spc_pkg.sv
rtl/spc_item_if.sv
rtl/spc_result_if.sv
rtl/sprite_pixel_collision_top.sv
bench/tb_sprite_pixel_collision_top.sv
